// ----- sv/tcas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_pkg: shared types and constants of the angle smoother
// Command and status words between the controller and the datapath, CORDIC
// widths and the arctangent table.
// ----------------------------------------------------------------------------
package tcas_pkg;

  localparam int IDX_W      = 6;   // holds any history index
  localparam int K_W        = 5;   // CORDIC iteration index
  localparam int COS_ITERS  = 16;
  localparam int ATAN_ITERS = 24;
  localparam int CX_W       = 18;  // rotation vector width
  localparam int Z_W        = 34;  // rotation residual angle width

  localparam logic signed [CX_W-1:0] CORDIC_X0 = 18'sd19898;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE,
    OP_LATJ,
    OP_CMP,
    OP_COS_INIT,
    OP_COS_STEP,
    OP_ACC,
    OP_ATAN_INIT,
    OP_ATAN_STEP,
    OP_FINISH
  } tcas_op_t;

  typedef struct packed {
    tcas_op_t         op;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] cmp_idx;
    logic [IDX_W-1:0] j_idx;
    logic [K_W-1:0]   k;
  } tcas_cmd_t;

  typedef struct packed {
    logic keep;
    logic out_busy;
  } tcas_sts_t;

  // arctangent of 2^-k, full circle = 2^32
  function automatic logic [31:0] atan_tab(input logic [K_W-1:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tcas_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcas_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 40
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/tcas_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_ctrl: sequencer of the angle smoother
// Steps through write, ranking, CORDIC and arctangent phases.
// ----------------------------------------------------------------------------
module tcas_ctrl #(
  parameter int WINDOW = 20
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  tcas_pkg::tcas_sts_t sts,
  output tcas_pkg::tcas_cmd_t cmd
);
  import tcas_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_RDJ, S_LATJ, S_CMP, S_SEL, S_COS, S_ACC, S_AINIT, S_ATAN, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W:0]   ic_r, ic_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             last_j;

  assign last_j    = (j_r == IDX_W'(WINDOW - 1));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    ic_nxt      = ic_r;
    k_nxt       = k_r;
    cmd.op      = OP_NONE;
    cmd.rd_idx  = j_r;
    cmd.cmp_idx = IDX_W'(ic_r - 1'b1);
    cmd.j_idx   = j_r;
    cmd.k       = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.op    = OP_WRITE;
        j_nxt     = '0;
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        state_nxt = S_LATJ;
      end
      S_LATJ: begin
        cmd.op    = OP_LATJ;
        ic_nxt    = '0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.rd_idx = (ic_r == (IDX_W+1)'(WINDOW)) ? '0 : ic_r[IDX_W-1:0];
        if (ic_r != '0) begin
          cmd.op = OP_CMP;
        end
        ic_nxt = ic_r + 1'b1;
        if (ic_r == (IDX_W+1)'(WINDOW)) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (sts.keep) begin
          cmd.op    = OP_COS_INIT;
          k_nxt     = '0;
          state_nxt = S_COS;
        end else if (last_j) begin
          state_nxt = S_AINIT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RDJ;
        end
      end
      S_COS: begin
        cmd.op = OP_COS_STEP;
        k_nxt  = k_r + 1'b1;
        if (k_r == K_W'(COS_ITERS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (last_j) begin
          state_nxt = S_AINIT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RDJ;
        end
      end
      S_AINIT: begin
        cmd.op    = OP_ATAN_INIT;
        k_nxt     = '0;
        state_nxt = S_ATAN;
      end
      S_ATAN: begin
        cmd.op = OP_ATAN_STEP;
        k_nxt  = k_r + 1'b1;
        if (k_r == K_W'(ATAN_ITERS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      ic_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      ic_r    <= ic_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tcas_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_dp: datapath of the angle smoother
// History RAM, distance ranking, CORDIC sine/cosine, sums, arctangent, output.
// ----------------------------------------------------------------------------
module tcas_dp #(
  parameter int WINDOW     = 20,
  parameter int DISCARD    = 2,
  parameter int CHANNELS   = 2,
  parameter int ANGLE_BITS = 14,
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tcas_pkg::tcas_cmd_t   cmd,
  output tcas_pkg::tcas_sts_t   sts,
  input  wire [CH_W-1:0]        in_ch,
  input  wire [ANGLE_BITS-1:0]  in_angle,
  input  wire                   out_tready,
  output logic                  out_valid,
  output logic [CH_W-1:0]       out_ch,
  output logic [ANGLE_BITS-1:0] out_tics,
  output logic                  out_undef
);
  import tcas_pkg::*;

  localparam int AB    = ANGLE_BITS;
  localparam int IW    = $clog2(WINDOW);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AD_W  = $clog2(DEPTH);
  localparam int D_EFF = (2 * DISCARD < WINDOW) ? DISCARD : (WINDOW - 1) / 2;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SW    = 17 + $clog2(WINDOW);
  localparam int AW    = SW + 18;
  localparam int PH_SH = 32 - AB;
  localparam logic [AB-1:0] HALF = {1'b1, {(AB-1){1'b0}}};

  function automatic logic [AB-1:0] wrap_dist(input logic [AB-1:0] h, input logic [AB-1:0] p);
    logic [AB-1:0] d;
    d = h - p;
    if (d > HALF) begin
      d = -d;
    end
    return d;
  endfunction

  function automatic logic signed [15:0] clamp_q15(input logic signed [CX_W-1:0] v);
    logic signed [15:0] c;
    if (v > CX_W'(32767)) begin
      c = 16'sd32767;
    end else if (v < -CX_W'(32767)) begin
      c = -16'sd32767;
    end else begin
      c = v[15:0];
    end
    return c;
  endfunction

  logic [CH_W-1:0]        ch_r;
  logic [AB-1:0]          ang_r;
  logic [IW-1:0]          ptr_r [CHANNELS];
  logic [AB-1:0]          sm_r [CHANNELS];
  logic [DEPTH-1:0]       vld_r;
  logic                   rvld_r;
  logic [AB-1:0]          aj_r, dj_r;
  logic [CW-1:0]          rank_r;
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0]  cz_r;
  logic                   flip_r;
  logic signed [SW-1:0]   sx_r, sy_r;
  logic signed [AW-1:0]   ax_r, ay_r;
  logic [31:0]            az_r;
  logic                   out_valid_r;
  logic [CH_W-1:0]        out_ch_r;
  logic [AB-1:0]          out_tics_r;
  logic                   out_undef_r;

  logic [CH_W-1:0]        ch_fold;
  logic [IW-1:0]          p_new;
  logic [AD_W-1:0]        base, waddr, raddr;
  logic [AB-1:0]          rdata, h_rd, d_rd;
  logic [31:0]            ph, phf, tab, rnd;
  logic                   flip;
  logic signed [CX_W-1:0] cdx, cdy, cxf, cyf;
  logic signed [15:0]     cc, cs;
  logic signed [Z_W-1:0]  ctab;
  logic signed [AW-1:0]   xe, ye, adx, ady;
  logic                   undef;

  assign ch_fold = (in_ch >= CHANNELS) ? in_ch - CH_W'(CHANNELS) : in_ch;
  assign p_new   = (ptr_r[ch_r] == IW'(WINDOW - 1)) ? '0 : ptr_r[ch_r] + 1'b1;
  assign base    = AD_W'(ch_r * WINDOW);
  assign waddr   = base + AD_W'(p_new);
  assign raddr   = base + AD_W'(cmd.rd_idx[IW-1:0]);

  tcas_ram #(.WIDTH(AB), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.op == OP_WRITE),
    .waddr (waddr),
    .wdata (ang_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // unwritten entries read as zero
  assign h_rd = rvld_r ? rdata : '0;
  assign d_rd = wrap_dist(h_rd, sm_r[ch_r]);

  assign sts.keep     = (rank_r >= CW'(D_EFF)) && (rank_r < CW'(WINDOW - D_EFF));
  assign sts.out_busy = out_valid_r && !out_tready;

  assign tab  = atan_tab(cmd.k);
  assign ph   = 32'(aj_r) << PH_SH;
  assign flip = ph[31] ^ ph[30];
  assign phf  = flip ? ph + HALF_TURN : ph;
  assign cdx  = cy_r >>> cmd.k;
  assign cdy  = cx_r >>> cmd.k;
  assign ctab = $signed({{(Z_W-32){1'b0}}, tab});
  assign cxf  = flip_r ? -cx_r : cx_r;
  assign cyf  = flip_r ? -cy_r : cy_r;
  assign cc   = clamp_q15(cxf);
  assign cs   = clamp_q15(cyf);

  assign xe  = {{(AW-SW){sx_r[SW-1]}}, sx_r};
  assign ye  = {{(AW-SW){sy_r[SW-1]}}, sy_r};
  assign adx = ay_r >>> cmd.k;
  assign ady = ax_r >>> cmd.k;

  assign undef = (sx_r == '0) && (sy_r == '0);
  assign rnd   = az_r + (32'h1 << (PH_SH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_r[c] <= '0;
        sm_r[c]  <= '0;
      end
      vld_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      // load a fresh result, else drop the one just taken
      if (cmd.op == OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          ch_r  <= ch_fold;
          ang_r <= in_angle;
        end
        OP_WRITE: begin
          ptr_r[ch_r]  <= p_new;
          vld_r[waddr] <= 1'b1;
          sx_r         <= '0;
          sy_r         <= '0;
        end
        OP_LATJ: begin
          aj_r   <= h_rd;
          dj_r   <= d_rd;
          rank_r <= '0;
        end
        OP_CMP: begin
          if ((d_rd < dj_r) || ((d_rd == dj_r) && (cmd.cmp_idx < cmd.j_idx))) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        OP_COS_INIT: begin
          cx_r   <= CORDIC_X0;
          cy_r   <= '0;
          cz_r   <= $signed({{(Z_W-32){phf[31]}}, phf});
          flip_r <= flip;
        end
        OP_COS_STEP: begin
          if (!cz_r[Z_W-1]) begin
            cx_r <= cx_r - cdx;
            cy_r <= cy_r + cdy;
            cz_r <= cz_r - ctab;
          end else begin
            cx_r <= cx_r + cdx;
            cy_r <= cy_r - cdy;
            cz_r <= cz_r + ctab;
          end
        end
        OP_ACC: begin
          sx_r <= sx_r + {{(SW-16){cc[15]}}, cc};
          sy_r <= sy_r + {{(SW-16){cs[15]}}, cs};
        end
        OP_ATAN_INIT: begin
          if (sx_r[SW-1]) begin
            ax_r <= (-xe) <<< 16;
            ay_r <= (-ye) <<< 16;
            az_r <= HALF_TURN;
          end else begin
            ax_r <= xe <<< 16;
            ay_r <= ye <<< 16;
            az_r <= '0;
          end
        end
        OP_ATAN_STEP: begin
          if (!ay_r[AW-1]) begin
            ax_r <= ax_r + adx;
            ay_r <= ay_r - ady;
            az_r <= az_r + tab;
          end else begin
            ax_r <= ax_r - adx;
            ay_r <= ay_r + ady;
            az_r <= az_r - tab;
          end
        end
        OP_FINISH: begin
          out_ch_r    <= ch_r;
          out_undef_r <= undef;
          out_tics_r  <= undef ? '0 : rnd[31 -: AB];
          sm_r[ch_r]  <= undef ? '0 : rnd[31 -: AB];
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_tics  = out_tics_r;
  assign out_undef = out_undef_r;

endmodule
`default_nettype wire

// ----- sv/trimmed_circular_angle_smoother.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trimmed_circular_angle_smoother: trimmed circular-mean filter for angles
// Per-channel history of rotary angles, outliers trimmed, mean via CORDIC.
// ----------------------------------------------------------------------------
// Each input transaction carries a channel and a raw angle. The angle is
// written into that channel's ring of WINDOW readings; all readings are then
// ranked by wrapped distance from the channel's last smoothed angle (ties keep
// slot order), the DISCARD nearest and farthest are dropped and the rest are
// averaged as unit vectors, and the mean direction comes back rounded to a
// tic. When the vector sum is zero the result is 0 with the undefined flag
// set. One item is in work at a time: the ranking compares every reading
// against every other through the single read port of the history RAM, and
// each kept reading costs 16 sine/cosine CORDIC steps, followed by 24
// arctangent steps. The result sits in an output register, so the next
// transaction is taken while it waits. History starts as all zero after
// reset, with no clearing pass.
module trimmed_circular_angle_smoother #(
  parameter int WINDOW     = 20,
  parameter int DISCARD    = 2,
  parameter int CHANNELS   = 2,
  parameter int ANGLE_BITS = 14,
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int TD_W      = ((ANGLE_BITS + 7) / 8) * 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire [TD_W-1:0]   in_tdata,   // angle_tics
  input  wire [CH_W-1:0]   in_tuser,   // channel
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [TD_W-1:0]  out_tdata,  // smoothed_tics
  output logic [CH_W:0]    out_tuser   // out_channel, mean_undefined
);
  import tcas_pkg::*;

  tcas_cmd_t             cmd;
  tcas_sts_t             sts;
  logic [CH_W-1:0]       out_ch;
  logic [ANGLE_BITS-1:0] out_tics;
  logic                  out_undef;

  // sequencer: owns the phase and all loop counters
  tcas_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: history, ranking, CORDIC and the output register
  tcas_dp #(
    .WINDOW     (WINDOW),
    .DISCARD    (DISCARD),
    .CHANNELS   (CHANNELS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_ch      (in_tuser),
    .in_angle   (in_tdata[ANGLE_BITS-1:0]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_ch     (out_ch),
    .out_tics   (out_tics),
    .out_undef  (out_undef)
  );

  // pad the angle out to whole bytes
  assign out_tdata = TD_W'(out_tics);
  assign out_tuser = {out_undef, out_ch};

endmodule
`default_nettype wire

// ----- sv/tcas_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_checker: port-level checks on the angle smoother
// Bound to the top level; watches only its ports.
// ----------------------------------------------------------------------------
module tcas_checker #(
  parameter int CHANNELS   = 2,
  parameter int ANGLE_BITS = 14,
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int TD_W      = ((ANGLE_BITS + 7) / 8) * 8
) (
  input wire            clk,
  input wire            rst_n,
  input wire            in_tvalid,
  input wire            in_tready,
  input wire [TD_W-1:0] in_tdata,
  input wire [CH_W-1:0] in_tuser,
  input wire            out_tvalid,
  input wire            out_tready,
  input wire [TD_W-1:0] out_tdata,
  input wire [CH_W:0]   out_tuser
);

  // one item in work: an accepted transaction blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[CH_W] |-> out_tdata[ANGLE_BITS-1:0] == '0)
    else $error("undefined mean with non-zero angle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending straight after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind trimmed_circular_angle_smoother tcas_checker #(
  .CHANNELS   (CHANNELS),
  .ANGLE_BITS (ANGLE_BITS)
) u_tcas_checker (.*);
`default_nettype wire

// ----- verif/tb_trimmed_circular_angle_smoother.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_trimmed_circular_angle_smoother: self-checking bench for the smoother
// Drives a short table of hand-picked angle transactions, then several
// hundred random ones (mostly noisy clusters per axis, some wild readings).
// A behavioural copy of the filter predicts every result, and a scoreboard
// compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_trimmed_circular_angle_smoother;
  import tcas_pkg::*;

  localparam int NWIN     = 20;
  localparam int NDROP    = 2;
  localparam int NCH      = 2;
  localparam int ABITS    = 14;
  localparam int FULL     = 1 << ABITS;
  localparam int HALF     = FULL / 2;
  localparam int NRANDOM  = 560;
  localparam int SETTLE   = 1000;  // clocks run on after the last result

  typedef struct packed {
    logic              ch;
    logic [ABITS-1:0]  tics;
    logic              undef;
  } smooth_res_t;

  typedef struct {
    logic              ch;
    logic [ABITS-1:0]  angle;
    logic              has_exp;
    smooth_res_t       exp;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // typed expectation travelling with the driven transaction
  logic        row_has_exp;
  smooth_res_t row_exp;

  int          idle_pct;
  int          stall_pct;
  int          n_errors;
  smooth_res_t pending_means[$];
  stim_row_t   dir_rows[$];

  // filter state of the predictor
  logic [ABITS-1:0] hist_q [NCH][NWIN];
  int               slot_q [NCH];
  logic [ABITS-1:0] last_mean_q [NCH];

  logic [31:0] arc_tab [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  trimmed_circular_angle_smoother dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // angle_tics
    .in_tuser   (in_tuser),    // channel
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // smoothed_tics
    .out_tuser  (out_tuser)    // out_channel, mean_undefined
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Unit vector of an angle in Q1.15: half-turn fold, 16 rotation steps,
  // arithmetic shifts round towards minus infinity.
  function automatic void unit_vector(input logic [31:0] ph, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy;
    logic   flip;
    x = 19898;
    y = 0;
    flip = ((ph + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) ph = ph + 32'h8000_0000;
    z = longint'($signed(ph));
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arc_tab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(arc_tab[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = (x > 32767) ? 32767 : (x < -32767) ? -32767 : x;
    s = (y > 32767) ? 32767 : (y < -32767) ? -32767 : y;
  endfunction

  function automatic logic [31:0] vector_phase(input longint x, input longint y);
    logic [31:0] z;
    longint      dx, dy;
    z = 32'h0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z = z + arc_tab[i];
      end else begin
        x -= dx; y += dy; z = z - arc_tab[i];
      end
    end
    return z;
  endfunction

  // Advance one channel's history and work out its next smoothed angle.
  function automatic smooth_res_t smooth_angle(input logic ch, input logic [ABITS-1:0] a);
    int          dist_v [NWIN];
    logic [13:0] ang [NWIN];
    int          d, j, t;
    logic [13:0] ta;
    longint      sx, sy, c, s;
    smooth_res_t r;
    sx = 0;
    sy = 0;
    slot_q[ch] = (slot_q[ch] + 1) % NWIN;
    hist_q[ch][slot_q[ch]] = a;
    for (int k = 0; k < NWIN; k++) begin
      d = (int'(hist_q[ch][k]) - int'(last_mean_q[ch])) & (FULL - 1);
      if (d > HALF) d = FULL - d;
      dist_v[k] = d;
      ang[k] = hist_q[ch][k];
    end
    // stable insertion sort by distance
    for (int k = 1; k < NWIN; k++) begin
      j = k;
      while (j > 0 && dist_v[j-1] > dist_v[j]) begin
        t = dist_v[j]; dist_v[j] = dist_v[j-1]; dist_v[j-1] = t;
        ta = ang[j]; ang[j] = ang[j-1]; ang[j-1] = ta;
        j--;
      end
    end
    for (int k = NDROP; k < NWIN - NDROP; k++) begin
      unit_vector({ang[k], 18'b0}, c, s);
      sx += c;
      sy += s;
    end
    r.ch = ch;
    r.undef = (sx == 0 && sy == 0);
    r.tics = '0;
    if (!r.undef) r.tics = 14'((longint'(vector_phase(sx, sy)) + 131072) >> 18);
    last_mean_q[ch] = r.tics;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  // Predict on every accepted input transaction.
  always @(posedge clk) begin
    smooth_res_t p;
    if (rst_n && in_tvalid && in_tready) begin
      p = smooth_angle(in_tuser[0], in_tdata[ABITS-1:0]);
      if (row_has_exp && p != row_exp)
        report_mismatch($sformatf("predictor gives %p, table expects %p", p, row_exp));
      pending_means.push_back(row_has_exp ? row_exp : p);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    smooth_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%0d tuser=%b", out_tdata, out_tuser));
      end else begin
        e = pending_means.pop_front();
        if (out_tuser[0] !== e.ch)
          report_mismatch($sformatf("channel %b, expected %b", out_tuser[0], e.ch));
        if (out_tdata !== {2'b00, e.tics})
          report_mismatch($sformatf("ch%0d smoothed %0d, expected %0d", e.ch, out_tdata, e.tics));
        if (out_tuser[1] !== e.undef)
          report_mismatch($sformatf("ch%0d undefined flag %b, expected %b",
                                    e.ch, out_tuser[1], e.undef));
      end
    end
  end

  // Receiver back-pressure at the current stall rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one transaction and hold it until taken. Valid is left high so
  // that back-to-back transactions never drop it.
  task automatic send_angle(input logic ch, input logic [ABITS-1:0] a,
                            input logic has_exp, input smooth_res_t exp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= {2'b00, a};
    in_tuser    <= ch;
    row_has_exp <= has_exp;
    row_exp     <= exp;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic add_row(input logic ch, input int a, input logic has_exp,
                         input int exp_tics, input logic exp_undef);
    stim_row_t r;
    r.ch = ch;
    r.angle = a[13:0];
    r.has_exp = has_exp;
    r.exp = '{ch: ch, tics: exp_tics[13:0], undef: exp_undef};
    dir_rows.push_back(r);
  endtask

  // Random angle: mostly a noisy reading around the axis centre, sometimes
  // a wild value anywhere on the circle.
  function automatic logic [ABITS-1:0] pick_angle(input int centre);
    int spread;
    if ($urandom_range(99) < 15) return 14'($urandom);
    spread = ($urandom_range(3) == 0) ? 2000 : 150;
    return 14'(centre + $urandom_range(2 * spread) - spread);
  endfunction

  initial begin
    int centre [NCH];
    int phase;
    logic ch;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    row_has_exp = 1'b0;
    row_exp     = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    n_errors    = 0;
    for (int c = 0; c < NCH; c++) begin
      slot_q[c] = 0;
      last_mean_q[c] = '0;
      for (int k = 0; k < NWIN; k++) hist_q[c][k] = '0;
    end

    // Fresh history is all zero: a lone half-turn reading is the farthest
    // and gets trimmed; a lone zero reading leaves the mean at zero.
    add_row(1'b1, HALF, 1'b1, 0, 1'b0);
    add_row(1'b0, 0, 1'b1, 0, 1'b0);
    add_row(1'b1, FULL - 1, 1'b0, 0, 1'b0);
    add_row(1'b1, 1, 1'b0, 0, 1'b0);
    add_row(1'b1, 12345, 1'b0, 0, 1'b0);
    // Axis 0: alternate zero and half-turn until the ring holds ten of each;
    // the kept vectors cancel exactly and the mean is undefined.
    for (int k = 1; k < NWIN; k++) add_row(1'b0, (k % 2) ? 0 : HALF, 1'b0, 0, 1'b0);
    add_row(1'b0, HALF, 1'b1, 0, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_angle(dir_rows[i].ch, dir_rows[i].angle, dir_rows[i].has_exp, dir_rows[i].exp);

    centre[0] = 16300;  // close to the wrap point
    centre[1] = $urandom_range(FULL - 1);
    for (int n = 0; n < NRANDOM; n++) begin
      phase = n / (NRANDOM / 4);
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 54; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      // hold off once until the pipe has drained
      if (n == NRANDOM / 2) begin
        in_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
      end
      // drift the cluster centres slowly, with an occasional jump
      if ($urandom_range(99) < 3) centre[$urandom_range(1)] = $urandom_range(FULL - 1);
      ch = 1'($urandom_range(1));
      centre[ch] = (centre[ch] + $urandom_range(40) - 20) & (FULL - 1);
      send_angle(ch, pick_angle(centre[ch]), 1'b0, '0);
    end
    in_tvalid   <= 1'b0;
    row_has_exp <= 1'b0;
    stall_pct = 0;

    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_errors == 0) begin
      $display("trimmed_circular_angle_smoother test passed");
    end else begin
      $display("trimmed_circular_angle_smoother test failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #8000000;
    $display("trimmed_circular_angle_smoother test failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
sv/tcas_pkg.sv
sv/tcas_ram.sv
sv/tcas_ctrl.sv
sv/tcas_dp.sv
sv/trimmed_circular_angle_smoother.sv
sv/tcas_checker.sv
verif/tb_trimmed_circular_angle_smoother.sv
